@@ rtl/sicnt_pkg.sv @@
// Shared constants and types for the sorted insert table with counts.
`default_nettype none
package sicnt_pkg;
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FILL_W   = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 16;
	localparam int POS_W    = 4;
	localparam int USED_W   = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Data handed from one cell to the next one up.
	typedef struct packed {
		logic                      vld;
		logic                      lt;
		logic signed [VALUE_W-1:0] val;
		logic [COUNT_W-1:0]        cnt;
	} link_t;

	// Broadcast command to every cell.
	typedef struct packed {
		logic upd;
		logic ins;
	} cmd_t;

	// Per-cell compare status for the result reduction.
	typedef struct packed {
		logic               bnd;
		logic               eq;
		logic [COUNT_W-1:0] cnt_inc;
	} stat_t;
endpackage
`default_nettype wire

@@ rtl/sorted_insert_with_counts_core.sv @@
// Top level: chain of table cells, result reduction and output register.
// The block keeps an ascending table of up to 16 distinct signed values with
// saturating occurrence counts. It takes one value per clock while the output
// register is empty or being drained: the key is broadcast to every cell of the
// chain, each cell compares it against its own entry in the same cycle, and on
// a miss the cell at the insertion point takes the key while every cell above it
// takes its lower neighbor's entry. The result beat is registered and appears
// in the cycle after the input beat is accepted. A distinct value that arrives
// with the table full is discarded and reported with position 0.
`default_nettype none
module sorted_insert_with_counts_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] new_value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [3:0]              position,
	output logic [15:0]             occurrences,
	output logic                    is_new,
	output logic                    dropped,
	output logic [4:0]              entries_in_use
);
	localparam int N = sicnt_pkg::CAPACITY;

	sicnt_pkg::link_t                link [N+1];
	sicnt_pkg::stat_t                stat [N];
	sicnt_pkg::cmd_t                 cmd;
	logic                            in_fire;
	logic                            any_eq;
	logic                            full;
	logic                            ins;
	logic [sicnt_pkg::IDX_W-1:0]     pos;
	logic [sicnt_pkg::COUNT_W-1:0]   occ;
	logic [sicnt_pkg::FILL_W-1:0]    fill_q;
	logic [sicnt_pkg::FILL_W-1:0]    fill_nxt;
	logic                            out_valid_q;

	// Below the first cell everything counts as smaller than the key
	assign link[0].vld = 1'b0;
	assign link[0].lt  = 1'b1;
	assign link[0].val = '0;
	assign link[0].cnt = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		sicnt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.key    (new_value),
			.cmd    (cmd),
			.prev   (link[i]),
			.cur    (link[i+1]),
			.stat   (stat[i])
		);
	end

	// Boundary is one-hot, so the reduction is a plain OR
	always_comb begin
		any_eq = 1'b0;
		pos    = '0;
		occ    = '0;
		for (int i = 0; i < N; i++) begin
			any_eq = any_eq | stat[i].eq;
			if (stat[i].bnd) begin
				pos = pos | sicnt_pkg::IDX_W'(i);
			end
			if (stat[i].eq) begin
				occ = occ | stat[i].cnt_inc;
			end
		end
	end

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign full     = (fill_q == sicnt_pkg::FILL_W'(N));
	assign ins      = in_fire && !any_eq && !full;
	assign cmd.upd  = in_fire && any_eq;
	assign cmd.ins  = ins;
	assign fill_nxt = fill_q + sicnt_pkg::FILL_W'(ins);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_nxt;
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			entries_in_use <= sicnt_pkg::USED_W'(fill_nxt);
			is_new         <= ins;
			dropped        <= !any_eq && full;
			if (!any_eq && full) begin
				position    <= '0;
				occurrences <= '0;
			end else begin
				position    <= sicnt_pkg::POS_W'(pos);
				occurrences <= any_eq ? occ : sicnt_pkg::COUNT_W'(1);
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

@@ rtl/sicnt_cell.sv @@
// One table slot: compares against the broadcast key, counts or shifts up.
`default_nettype none
module sicnt_cell (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic signed [sicnt_pkg::VALUE_W-1:0] key,
	input  wire sicnt_pkg::cmd_t                   cmd,
	input  wire sicnt_pkg::link_t                  prev,
	output sicnt_pkg::link_t                       cur,
	output sicnt_pkg::stat_t                       stat
);
	logic                                  vld_q;
	logic signed [sicnt_pkg::VALUE_W-1:0]  val_q;
	logic [sicnt_pkg::COUNT_W-1:0]         cnt_q;
	logic                                  lt;
	logic                                  eq;
	logic [sicnt_pkg::COUNT_W-1:0]         cnt_inc;

	assign lt      = vld_q && (val_q < key);
	assign eq      = vld_q && (val_q == key);
	assign cnt_inc = (cnt_q == sicnt_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;

	assign cur.vld = vld_q;
	assign cur.lt  = lt;
	assign cur.val = val_q;
	assign cur.cnt = cnt_q;

	// First slot not below the key: match or insertion point
	assign stat.bnd     = prev.lt && !lt;
	assign stat.eq      = eq;
	assign stat.cnt_inc = cnt_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.ins && !lt) begin
			vld_q <= prev.lt ? 1'b1 : prev.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && eq) begin
			cnt_q <= cnt_inc;
		end else if (cmd.ins && !lt) begin
			if (prev.lt) begin
				val_q <= key;
				cnt_q <= sicnt_pkg::COUNT_W'(1);
			end else begin
				val_q <= prev.val;
				cnt_q <= prev.cnt;
			end
		end
	end
endmodule
`default_nettype wire
